FILE: src/hkv_pkg.sv
`default_nettype none

package hkv_pkg;

    // result kinds
    localparam logic [2:0] KIND_KEY_BYTE  = 3'd0;
    localparam logic [2:0] KIND_VAL_BYTE  = 3'd1;
    localparam logic [2:0] KIND_KEY_DONE  = 3'd2;
    localparam logic [2:0] KIND_PAIR_DONE = 3'd3;
    localparam logic [2:0] KIND_PAIR_DROP = 3'd4;
    localparam logic [2:0] KIND_STREAM_END = 3'd5;

    // parse phases
    localparam logic [1:0] PH_KEY   = 2'd0;
    localparam logic [1:0] PH_VALUE = 2'd1;
    localparam logic [1:0] PH_SKIP  = 2'd2;

    // escape phases
    localparam logic [1:0] ESC_NONE   = 2'd0;
    localparam logic [1:0] ESC_FIRST  = 2'd1;
    localparam logic [1:0] ESC_SECOND = 2'd2;

    // mode register values
    localparam logic MODE_QUERY  = 1'b0;
    localparam logic MODE_COOKIE = 1'b1;

    // characters
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       bad;
    } res_t;

    // results of one item, filled from index 0
    typedef struct packed {
        res_t [MAX_RESULTS-1:0] res;
        logic [1:0]             count;
    } bundle_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       key_pending;
        logic [1:0] esc_phase;
        logic [7:0] esc_value;
        logic [1:0] esc_digits;
        logic       esc_stopped;
    } state_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       key_pending;
        logic       emit;
        res_t       res;
    } split_t;

endpackage

`default_nettype wire

FILE: src/hkv_text_if.sv
`default_nettype none

interface hkv_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       last;

    modport source (output valid, output raw_byte, output last, input ready);
    modport sink (input valid, input raw_byte, input last, output ready);
endinterface

`default_nettype wire

FILE: src/hkv_token_if.sv
`default_nettype none

interface hkv_token_if;
    logic       valid;
    logic       ready;
    logic [2:0] out_kind;
    logic [7:0] data_byte;
    logic       bad_escape;
    logic       run_last;

    modport source (output valid, output out_kind, output data_byte, output bad_escape,
                    output run_last, input ready);
    modport sink (input valid, input out_kind, input data_byte, input bad_escape,
                  input run_last, output ready);
endinterface

`default_nettype wire

FILE: src/hkv_decode.sv
`default_nettype none

module hkv_decode (
    input  wire logic             mode,
    input  wire logic [7:0]       raw_byte,
    input  wire logic             last,
    input  wire hkv_pkg::state_t  state,
    output hkv_pkg::state_t       state_next,
    output hkv_pkg::bundle_t      bundle
);
    import hkv_pkg::*;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd16;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = 5'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = 5'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = 5'(c - 8'h57);
        end
        return r;
    endfunction

    // key/value split of one decoded byte
    function automatic split_t split_byte(input logic [1:0] phase, input logic key_pending,
                                          input logic md, input logic [7:0] b,
                                          input logic bad);
        split_t     o;
        logic [7:0] sep;
        o.phase       = phase;
        o.key_pending = key_pending;
        o.emit        = 1'b1;
        o.res         = '{kind: KIND_KEY_BYTE, data: 8'd0, bad: 1'b0};
        sep           = (md == MODE_COOKIE) ? CH_SEMI : CH_AMP;
        if (phase == PH_VALUE)
        begin
            if (b == sep)
            begin
                o.res.kind = KIND_PAIR_DONE;
                o.phase    = (md == MODE_COOKIE) ? PH_SKIP : PH_KEY;
            end
            else
            begin
                o.res = '{kind: KIND_VAL_BYTE, data: b, bad: bad};
            end
        end
        else if (phase == PH_SKIP && md == MODE_COOKIE && b == CH_SPACE)
        begin
            o.emit = 1'b0;
        end
        else if (b == CH_EQUAL)
        begin
            o.res.kind      = KIND_KEY_DONE;
            o.phase         = PH_VALUE;
            o.key_pending   = 1'b0;
        end
        else
        begin
            o.res         = '{kind: KIND_KEY_BYTE, data: b, bad: bad};
            o.phase       = PH_KEY;
            o.key_pending = 1'b1;
        end
        return o;
    endfunction

    function automatic bundle_t push(input bundle_t bi, input res_t r);
        bundle_t bo;
        bo = bi;
        if (bi.count != 2'(MAX_RESULTS))
        begin
            bo.res[bi.count] = r;
            bo.count         = bi.count + 2'd1;
        end
        return bo;
    endfunction

    logic [4:0] digit;
    logic [7:0] flush_byte;
    logic       flush_bad;
    state_t     s;
    bundle_t    b;
    split_t     sp;
    split_t     sp_end;

    assign digit = hex_val(raw_byte);

    always_comb
    begin
        s          = state;
        b          = '0;
        sp         = '0;
        sp_end     = '0;
        flush_byte = 8'd0;
        flush_bad  = 1'b0;

        // decode the raw byte, then split what it yields
        if (mode == MODE_COOKIE)
        begin
            sp = split_byte(s.phase, s.key_pending, mode, raw_byte, 1'b0);
        end
        else if (s.esc_phase == ESC_FIRST)
        begin
            if (!digit[4])
            begin
                s.esc_value  = {4'd0, digit[3:0]};
                s.esc_digits = 2'd1;
            end
            else
            begin
                s.esc_stopped = 1'b1;
            end
            s.esc_phase = ESC_SECOND;
        end
        else if (s.esc_phase != ESC_NONE)
        begin
            if (!s.esc_stopped && !digit[4])
            begin
                s.esc_value  = {s.esc_value[3:0], digit[3:0]};
                s.esc_digits = s.esc_digits + 2'd1;
            end
            flush_byte  = s.esc_value;
            flush_bad   = (s.esc_digits == 2'd0);
            s.esc_phase   = ESC_NONE;
            s.esc_value   = 8'd0;
            s.esc_digits  = 2'd0;
            s.esc_stopped = 1'b0;
            sp = split_byte(s.phase, s.key_pending, mode, flush_byte, flush_bad);
        end
        else if (raw_byte == CH_PERCENT)
        begin
            s.esc_phase   = ESC_FIRST;
            s.esc_value   = 8'd0;
            s.esc_digits  = 2'd0;
            s.esc_stopped = 1'b0;
        end
        else if (raw_byte == CH_PLUS)
        begin
            sp = split_byte(s.phase, s.key_pending, mode, CH_SPACE, 1'b0);
        end
        else
        begin
            sp = split_byte(s.phase, s.key_pending, mode, raw_byte, 1'b0);
        end

        if (sp.emit)
        begin
            s.phase       = sp.phase;
            s.key_pending = sp.key_pending;
            b             = push(b, sp.res);
        end

        // end of text: flush an open escape, close the pair or drop the key, mark the end
        if (last)
        begin
            if (s.esc_phase != ESC_NONE)
            begin
                sp_end = split_byte(s.phase, s.key_pending, mode, s.esc_value, 1'b1);
                if (sp_end.emit)
                begin
                    s.phase       = sp_end.phase;
                    s.key_pending = sp_end.key_pending;
                    b             = push(b, sp_end.res);
                end
            end
            if (s.phase == PH_VALUE)
            begin
                b = push(b, '{kind: KIND_PAIR_DONE, data: 8'd0, bad: 1'b0});
            end
            else if (s.phase != PH_SKIP && s.key_pending)
            begin
                b = push(b, '{kind: KIND_PAIR_DROP, data: 8'd0, bad: 1'b0});
            end
            b = push(b, '{kind: KIND_STREAM_END, data: 8'd0, bad: 1'b0});
            s = '0;
        end
    end

    assign state_next = s;
    assign bundle     = b;

endmodule

`default_nettype wire

FILE: src/hkv_outbuf.sv
`default_nettype none

module hkv_outbuf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire hkv_pkg::bundle_t load_bundle,
    output logic                  free,
    hkv_token_if.source           token
);
    import hkv_pkg::*;

    bundle_t    bundle_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       take;
    logic       final_take;
    logic       at_final;

    assign at_final   = (idx_reg == bundle_reg.count - 2'd1);
    assign take       = valid_reg && token.ready;
    assign final_take = take && at_final;
    assign free       = !valid_reg || final_take;
    assign idx_next   = idx_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (final_take)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (take)
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bundle_reg <= load_bundle;
        end
    end

    assign token.valid      = valid_reg;
    assign token.out_kind   = bundle_reg.res[idx_reg].kind;
    assign token.data_byte  = bundle_reg.res[idx_reg].data;
    assign token.bad_escape = bundle_reg.res[idx_reg].bad;
    assign token.run_last   = at_final;

endmodule

`default_nettype wire

FILE: src/http_key_value_tokenizer.sv
`default_nettype none

// Query-string / cookie tokenizer. Raw text bytes enter on the text channel,
// one byte per item, with last on the final byte of a text. Each byte yields
// zero to three tokens on the token channel: key bytes, value bytes, key done,
// pair done, pair dropped and stream end, with run_last on the final token of
// a byte. In query mode (mode register at address 0, value 0) bytes are
// URL-decoded first: '+' turns into a space and '%' takes the next two bytes
// as hex digits; an escape with no digit, or one cut off by the end of text,
// is flagged by bad_escape. In cookie mode (value 1) ';' closes a pair and
// spaces after it are skipped. The block takes one byte per cycle unless the
// output holds it up: a byte sits in the input register, is decoded and
// split combinationally, and its tokens go to the output buffer, which drains
// one token a cycle while the receiver is ready. A byte with tokens waits
// for a free buffer; a byte with none (an escape being opened or read) does
// not. Change the mode only while no text is in flight.
module http_key_value_tokenizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    hkv_text_if.sink         text,
    hkv_token_if.source      token
);
    import hkv_pkg::*;

    localparam logic REG_MODE = 1'b0;   // paddr[2] of the mode register

    logic       mode_reg;
    logic       item_valid_reg;
    logic [7:0] item_byte_reg;
    logic       item_last_reg;
    state_t     state_reg;
    state_t     state_next;
    bundle_t    dec_bundle;
    logic       buf_free;
    logic       advance;
    logic       load;
    logic       text_take;
    logic       cfg_write;

    // configuration: write in the access phase, no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MODE);
    assign prdata    = (paddr[2] == REG_MODE) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_QUERY;
        end
        else if (cfg_write)
        begin
            mode_reg <= pwdata[0];
        end
    end

    // advance the held byte when its tokens fit: none to deliver, or the
    // output buffer is empty or empties this cycle
    assign advance   = item_valid_reg && ((dec_bundle.count == 2'd0) || buf_free);
    assign load      = advance && (dec_bundle.count != 2'd0);
    assign text.ready = !item_valid_reg || advance;
    assign text_take = text.valid && text.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (text_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_take)
        begin
            item_byte_reg <= text.raw_byte;
            item_last_reg <= text.last;
        end
    end

    hkv_decode u_decode (
        .mode       (mode_reg),
        .raw_byte   (item_byte_reg),
        .last       (item_last_reg),
        .state      (state_reg),
        .state_next (state_next),
        .bundle     (dec_bundle)
    );

    hkv_outbuf u_outbuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .load_bundle (dec_bundle),
        .free        (buf_free),
        .token       (token)
    );

    // tokens go to the buffer only when it is empty or draining its last one
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> buf_free)
        else $error("tokens loaded over undelivered tokens");

    // the end of a text leaves the parser and escape state cleared
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_last_reg |=> state_reg == '0)
        else $error("state not cleared after end of text");

    // a final byte always produces at least the stream end token
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && item_last_reg |-> dec_bundle.count != 2'd0)
        else $error("final byte without stream end");

endmodule

`default_nettype wire

FILE: dv/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hkv_pkg::*;

    // APB byte address of the mode register
    localparam logic [2:0] REG_MODE = 3'd0;

    // stop condition for the random part, counted in accepted text items
    localparam int TOTAL_ITEMS = 265;
    // hard limit on the run, far above the slowest legal run
    localparam int CYCLE_LIMIT = 200000;
    // cycles to let the block settle after the last token before a register write
    localparam int SETTLE_CYCLES = 8;
    // receiver hold-off that backs up the output buffer and stalls the text input
    localparam int HOLD_OFF_CYCLES = 300;

    // one token as it leaves the block
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       bad;
        logic       run_last;
    } token_t;

    // one row of the directed text table; typed tokens are used when n_typed is
    // not zero, otherwise the tokens come from the tokenizer model below
    typedef struct packed {
        logic         mode_set;
        logic         mode_val;
        logic [7:0]   raw;
        logic         last;
        logic [1:0]   n_typed;
        token_t [0:2] typed;
    } dir_row_t;

    localparam token_t NO_TOK = '0;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hkv_text_if  text_ch ();
    hkv_token_if token_ch ();

    http_key_value_tokenizer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .text    (text_ch),
        .token   (token_ch)
    );

    // Tokenizer model state, mirrors the block after reset
    logic       cfg_mode   = MODE_QUERY;
    logic [1:0] ph         = PH_KEY;
    logic       key_open   = 1'b0;
    logic [1:0] esc_ph     = ESC_NONE;
    logic [7:0] esc_val    = '0;
    logic [1:0] esc_cnt    = '0;
    logic       esc_stop   = 1'b0;

    res_t   step_tokens[$];     // tokens of the byte being predicted
    token_t expected_tokens[$]; // tokens still owed by the block, oldest first
    logic [7:0] text_buf[$];    // bytes of the next random text

    int  mismatches   = 0;
    int  items_sent   = 0;
    int  cycle_count  = 0;
    bit  calm         = 1'b0;   // no idling on either side while set
    bit  stall_req    = 1'b0;   // ask the receiver for one long hold-off
    int  hold_cycles  = 0;

    // Directed texts: separators inside a key, extra '=' in a value, '+' and
    // escapes, escape with no digit, escape with one digit then a non-hex byte,
    // a decoded '&' and '=', a dropped key, a truncated escape at the end, and
    // cookie mode with a space skipped after ';' right at the end.
    dir_row_t dir_tab [25] = '{
        // query text: key bytes, '=' handling, escapes, dropped key at the end
        '{1'b0, MODE_QUERY, 8'h00,      1'b0, 2'd1,
          '{'{KIND_KEY_BYTE, 8'h00, 1'b0, 1'b1}, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, CH_AMP,     1'b0, 2'd1,
          '{'{KIND_KEY_BYTE, CH_AMP, 1'b0, 1'b1}, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, CH_EQUAL,   1'b0, 2'd1,
          '{'{KIND_KEY_DONE, 8'h00, 1'b0, 1'b1}, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, CH_EQUAL,   1'b0, 2'd1,
          '{'{KIND_VAL_BYTE, CH_EQUAL, 1'b0, 1'b1}, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, CH_PLUS,    1'b0, 2'd1,
          '{'{KIND_VAL_BYTE, CH_SPACE, 1'b0, 1'b1}, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, CH_PERCENT, 1'b0, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, CH_PERCENT, 1'b0, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, CH_PLUS,    1'b0, 2'd1,
          '{'{KIND_VAL_BYTE, 8'h00, 1'b1, 1'b1}, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, CH_PERCENT, 1'b0, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, "2",        1'b0, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, "6",        1'b0, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, CH_PERCENT, 1'b0, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, "F",        1'b0, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, "z",        1'b0, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, 8'hFF,      1'b1, 2'd3,
          '{'{KIND_KEY_BYTE, 8'hFF, 1'b0, 1'b0},
            '{KIND_PAIR_DROP, 8'h00, 1'b0, 1'b0},
            '{KIND_STREAM_END, 8'h00, 1'b0, 1'b1}}},
        // query text: decoded '=' ends the key, open value closed at the end
        '{1'b0, MODE_QUERY, CH_PERCENT, 1'b0, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, "3",        1'b0, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, "d",        1'b0, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, "v",        1'b1, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        // query text: escape cut off by the end of text
        '{1'b0, MODE_QUERY, CH_PERCENT, 1'b0, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        '{1'b0, MODE_QUERY, "a",        1'b1, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        // cookie text: pair closed by ';', trailing space skipped
        '{1'b1, MODE_COOKIE, "k",       1'b0, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        '{1'b0, MODE_COOKIE, CH_EQUAL,  1'b0, 2'd0, '{NO_TOK, NO_TOK, NO_TOK}},
        '{1'b0, MODE_COOKIE, CH_SEMI,   1'b0, 2'd1,
          '{'{KIND_PAIR_DONE, 8'h00, 1'b0, 1'b1}, NO_TOK, NO_TOK}},
        '{1'b0, MODE_COOKIE, CH_SPACE,  1'b1, 2'd1,
          '{'{KIND_STREAM_END, 8'h00, 1'b0, 1'b1}, NO_TOK, NO_TOK}}
    };

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tokenizer model
    // ------------------------------------------------------------------

    // hex value of a character, 16 when it is not a hex digit
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 5'(c - "0");
        if (c >= "A" && c <= "F")
            return 5'(c - "A" + 8'd10);
        if (c >= "a" && c <= "f")
            return 5'(c - "a" + 8'd10);
        return 5'd16;
    endfunction

    // queue one token of the current byte, never more than the block can give
    function automatic void add_token(logic [2:0] kind, logic [7:0] data, logic bad);
        res_t r;
        r.kind = kind;
        r.data = data;
        r.bad  = bad;
        if (step_tokens.size() < MAX_RESULTS)
            step_tokens.push_back(r);
    endfunction

    function automatic void clear_escape();
        esc_ph   = ESC_NONE;
        esc_val  = '0;
        esc_cnt  = '0;
        esc_stop = 1'b0;
    endfunction

    // split one decoded byte into key / value tokens and pair markers
    function automatic void split_byte(logic [7:0] b, logic bad);
        logic [7:0] sep;
        sep = (cfg_mode == MODE_COOKIE) ? CH_SEMI : CH_AMP;
        if (ph == PH_VALUE) begin
            if (b == sep) begin
                add_token(KIND_PAIR_DONE, 8'h00, 1'b0);
                ph = (cfg_mode == MODE_COOKIE) ? PH_SKIP : PH_KEY;
            end
            else begin
                add_token(KIND_VAL_BYTE, b, bad);
            end
        end
        // a space right after ';' in cookie mode is dropped silently
        else if (!(ph == PH_SKIP && cfg_mode == MODE_COOKIE && b == CH_SPACE)) begin
            ph = PH_KEY;
            if (b == CH_EQUAL) begin
                add_token(KIND_KEY_DONE, 8'h00, 1'b0);
                ph       = PH_VALUE;
                key_open = 1'b0;
            end
            else begin
                add_token(KIND_KEY_BYTE, b, bad);
                key_open = 1'b1;
            end
        end
    endfunction

    // advance the model by one accepted text byte; tokens land in step_tokens
    function automatic void tokenize_byte(logic [7:0] raw, logic lst);
        logic [4:0] d;
        logic [7:0] v;
        logic       bad;
        step_tokens.delete();
        if (cfg_mode == MODE_COOKIE) begin
            split_byte(raw, 1'b0);
        end
        else if (esc_ph == ESC_FIRST) begin
            d = hex_digit(raw);
            if (d < 5'd16) begin
                esc_val = {4'h0, d[3:0]};
                esc_cnt = 2'd1;
            end
            else begin
                esc_stop = 1'b1;
            end
            esc_ph = ESC_SECOND;
        end
        else if (esc_ph != ESC_NONE) begin
            d = hex_digit(raw);
            if (!esc_stop && d < 5'd16) begin
                esc_val = {esc_val[3:0], d[3:0]};
                esc_cnt = esc_cnt + 2'd1;
            end
            v   = esc_val;
            bad = (esc_cnt == 2'd0);
            clear_escape();
            split_byte(v, bad);
        end
        else if (raw == CH_PERCENT) begin
            clear_escape();
            esc_ph = ESC_FIRST;
        end
        else if (raw == CH_PLUS) begin
            split_byte(CH_SPACE, 1'b0);
        end
        else begin
            split_byte(raw, 1'b0);
        end

        if (lst) begin
            // an escape still open at the end gives what it has, flagged
            if (esc_ph != ESC_NONE) begin
                v = esc_val;
                clear_escape();
                split_byte(v, 1'b1);
            end
            if (ph == PH_VALUE)
                add_token(KIND_PAIR_DONE, 8'h00, 1'b0);
            else if (ph != PH_SKIP && key_open)
                add_token(KIND_PAIR_DROP, 8'h00, 1'b0);
            add_token(KIND_STREAM_END, 8'h00, 1'b0);
            ph       = PH_KEY;
            key_open = 1'b0;
            clear_escape();
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one text byte, hold it until accepted, then book its tokens.
    // Typed tokens from the directed table replace the model's tokens; the
    // model still runs so that its state keeps up with the block.
    // A random gap before about one byte in five keeps the sender
    // idle in roughly a third of its cycles.
    task automatic send_byte(input logic [7:0] raw, input logic lst,
                             input logic [1:0] n_typed, input token_t [0:2] typed);
        int     gap;
        token_t t;
        if (!calm && $urandom_range(99) < 19) begin
            text_ch.valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        text_ch.valid    <= 1'b1;
        text_ch.raw_byte <= raw;
        text_ch.last     <= lst;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        tokenize_byte(raw, lst);
        if (n_typed != 2'd0) begin
            for (int i = 0; i < n_typed; i++)
                expected_tokens.push_back(typed[i]);
        end
        else begin
            foreach (step_tokens[i]) begin
                t.kind     = step_tokens[i].kind;
                t.data     = step_tokens[i].data;
                t.bad      = step_tokens[i].bad;
                t.run_last = (i == step_tokens.size() - 1);
                expected_tokens.push_back(t);
            end
        end
        items_sent++;
    endtask

    // Write the mode register once the block has drained and settled.
    task automatic write_mode(input logic v);
        text_ch.valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MODE;
        pwdata  <= {31'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_mode = v;
    endtask

    function automatic logic [7:0] pick_hex();
        int r;
        r = $urandom_range(21);
        if (r < 10)
            return 8'("0" + r);
        if (r < 16)
            return 8'("A" + r - 10);
        return 8'("a" + r - 16);
    endfunction

    // Build a random text: mostly well-formed pairs and escapes for the current
    // mode, with some broken escapes, foreign separators and arbitrary bytes.
    task automatic build_text(input int len);
        int r;
        text_buf.delete();
        while (text_buf.size() < len) begin
            r = $urandom_range(99);
            if (r < 30)
                text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
            else if (r < 40)
                text_buf.push_back(pick_hex());
            else if (r < 50)
                text_buf.push_back(CH_EQUAL);
            else if (r < 60)
                text_buf.push_back(cfg_mode == MODE_COOKIE ? CH_SEMI : CH_AMP);
            else if (r < 66)
                text_buf.push_back(cfg_mode == MODE_COOKIE ? CH_AMP : CH_SEMI);
            else if (r < 72)
                text_buf.push_back(CH_PLUS);
            else if (r < 82) begin
                text_buf.push_back(CH_PERCENT);
                // most escapes in query mode carry two proper hex digits
                if (cfg_mode == MODE_QUERY && $urandom_range(4) != 0) begin
                    text_buf.push_back(pick_hex());
                    text_buf.push_back(pick_hex());
                end
            end
            else if (r < 90)
                text_buf.push_back(CH_SPACE);
            else
                text_buf.push_back(8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int  text_no;
        int  text_len;
        bit  hold_off_done;
        text_no       = 0;
        hold_off_done = 1'b0;

        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        text_ch.valid    = 1'b0;
        text_ch.raw_byte = '0;
        text_ch.last     = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed texts, mode starts from its reset value
        foreach (dir_tab[i]) begin
            if (dir_tab[i].mode_set)
                write_mode(dir_tab[i].mode_val);
            send_byte(dir_tab[i].raw, dir_tab[i].last, dir_tab[i].n_typed,
                      dir_tab[i].typed);
        end

        // random texts; the first one puts the block back into query mode
        while (items_sent < TOTAL_ITEMS) begin
            if (text_no == 0)
                write_mode(MODE_QUERY);
            else if ($urandom_range(2) == 0)
                write_mode($urandom_range(1) ? MODE_COOKIE : MODE_QUERY);

            if (!hold_off_done && items_sent >= 120) begin
                // long text while the receiver holds off: the output buffer
                // fills and the text input must stall
                text_len      = 40;
                stall_req     = 1'b1;
                hold_off_done = 1'b1;
            end
            else if ($urandom_range(7) == 0)
                text_len = $urandom_range(12, 30);
            else
                text_len = $urandom_range(1, 10);

            calm = (items_sent >= 200 && items_sent < 240);
            build_text(text_len);
            foreach (text_buf[i])
                send_byte(text_buf[i], i == text_buf.size() - 1, 2'd0,
                          '{NO_TOK, NO_TOK, NO_TOK});
            text_no++;
        end

        // drain, let the block settle, then report
        text_ch.valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Token receiver: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        token_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (stall_req) begin
                hold_cycles = HOLD_OFF_CYCLES;
                stall_req   = 1'b0;
            end
            if (hold_cycles > 0) begin
                token_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else begin
                token_ch.ready <= calm || ($urandom_range(99) >= 32);
            end
        end
    end

    // ------------------------------------------------------------------
    // Token checker: compare each accepted token with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        token_t exp_tok;
        if (rst_n && token_ch.valid && token_ch.ready) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected token: out_kind %0d data_byte %0h",
                       token_ch.out_kind, token_ch.data_byte);
                mismatches++;
            end
            else begin
                exp_tok = expected_tokens.pop_front();
                if (token_ch.out_kind !== exp_tok.kind) begin
                    $error("out_kind: expected %0d, got %0d", exp_tok.kind,
                           token_ch.out_kind);
                    mismatches++;
                end
                if (token_ch.data_byte !== exp_tok.data) begin
                    $error("data_byte: expected %0h, got %0h", exp_tok.data,
                           token_ch.data_byte);
                    mismatches++;
                end
                if (token_ch.bad_escape !== exp_tok.bad) begin
                    $error("bad_escape: expected %0d, got %0d", exp_tok.bad,
                           token_ch.bad_escape);
                    mismatches++;
                end
                if (token_ch.run_last !== exp_tok.run_last) begin
                    $error("run_last: expected %0d, got %0d", exp_tok.run_last,
                           token_ch.run_last);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

endmodule

`default_nettype wire
